// ===== hdl/emt_pkg.sv =====
package emt_pkg;

  localparam int DIGIT_W      = 4;
  localparam int ACC_W        = 64;
  localparam int RAW_W        = 32;
  localparam int RAW_MAX_BITS = 32;
  localparam int BITS_W       = 6;
  localparam int N_DIGITS     = ACC_W / DIGIT_W;
  localparam int RAW_DIGITS   = RAW_W / DIGIT_W;
  localparam int DIG_IDX_W    = $clog2(N_DIGITS);
  localparam int RAW_IDX_W    = $clog2(RAW_DIGITS);
  localparam int DIV_CNT_W    = $clog2(ACC_W);

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = ACC_W;

  localparam int IN_FIELDS_W  = 2 * RAW_W + 2;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * ACC_W + 3;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_BITS       = 2'd0,
    CFG_HOME_RAW       = 2'd1,
    CFG_COUNTS_PER_REV = 2'd2,
    CFG_START_COUNT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_A,
    ST_PREP,
    ST_DIVIDE,
    ST_FOLD,
    ST_SIDE,
    ST_PASS_C,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REF_KEEP,
    REF_SNAP,
    REF_ABS,
    REF_LATCH
  } ref_src_t;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_POS  = 2'd1,
    SIDE_NEG  = 2'd2
  } side_t;

  typedef struct packed {
    logic   carry;
    logic   sgn;
    digit_t ext;
  } wrap_t;

  typedef struct packed {
    logic   carry;
    digit_t sum;
  } sum_t;

  // Carry, sign and zero state of the first digit pass
  typedef struct packed {
    logic c_d1;
    logic s_d1;
    logic c_d2;
    logic s_d2;
    logic c_d3;
    logic s_d3;
    logic c_acc;
    logic c_abs;
    logic c_lref;
    logic c_neg;
    logic zero;
  } chain_a_t;

  localparam chain_a_t CHAIN_A_INIT = '{
    c_d1: 1'b1, s_d1: 1'b0, c_d2: 1'b1, s_d2: 1'b0, c_d3: 1'b1, s_d3: 1'b0,
    c_acc: 1'b0, c_abs: 1'b0, c_lref: 1'b0, c_neg: 1'b1, zero: 1'b1
  };

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

  function automatic sum_t add_digit(input digit_t a, input digit_t b, input logic cin);
    sum_t r;
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{DIGIT_W{1'b0}}, cin};
    r.carry = s[DIGIT_W];
    r.sum   = s[DIGIT_W-1:0];
    return r;
  endfunction

  // One digit of (a - b) mod 2^bits, sign-extended above bit bits-1.
  function automatic wrap_t wrap_digit(input digit_t a, input digit_t b, input logic cin,
                                       input logic sgn_in, input logic [DIG_IDX_W-1:0] k,
                                       input logic [BITS_W-1:0] bits);
    wrap_t r;
    logic c;
    logic s;
    logic d;
    logic [BITS_W-1:0] pos;
    c = cin;
    s = sgn_in;
    r.ext = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      pos = BITS_W'(int'(k) * DIGIT_W + j);
      d = a[j] ^ ~b[j] ^ c;
      c = (a[j] & ~b[j]) | (a[j] & c) | (~b[j] & c);
      if (pos < bits) begin
        r.ext[j] = d;
        if (pos == bits - BITS_W'(1)) begin
          s = d;
        end
      end else begin
        r.ext[j] = s;
      end
    end
    r.carry = c;
    r.sgn   = s;
    return r;
  endfunction

endpackage

// ===== hdl/encoder_multiturn_tracker.sv =====
// Multiturn encoder tracker. Each input transaction carries one raw encoder sample; the
// wrapped signed step from the previous sample is added to a 64-bit count, and one result
// transaction returns the encoder, home-relative, reference-relative and reference counts
// with the home-side flags and the index enable after homing. The 64-bit arithmetic runs
// through shift registers one 4-bit digit per cycle. Each accepted item goes through the
// delta and count pass, a preparation state, the reference pass and a hand-over state back
// to idle, where the next transaction is taken. A previous result that is not yet taken
// holds the block in the hand-over state. With index_enable set and at least four counts
// per revolution a bit-serial restoring divider forms the position modulo counts_per_rev
// after the preparation state, followed by a fold and a side state. One item is worked on
// at a time; the next is accepted while the previous result still waits in the output
// register. The user must write configuration via cfg_we, cfg_index and cfg_data while
// the block is idle, which it does not enforce; writing start_count also loads the count.
module encoder_multiturn_tracker import emt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // raw_count, latch_raw, index_enable, position_reset, zero fill
  input  logic [IN_W-1:0]      s_tdata,
  // latch_valid
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // encoder_count, absolute_count, relative_count, reference_count,
  // at_or_below_home, at_or_above_home, index_enable_out, zero fill
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state;
  state_t state_next;

  logic [BITS_W-1:0]    bits_cfg;
  logic [RAW_W-1:0]     home_raw;
  logic [RAW_W-1:0]     counts_per_rev;

  logic [DIG_IDX_W-1:0] cnt;
  logic [ACC_W-1:0]     acc_sr;
  logic [ACC_W-1:0]     abs_sr;
  logic [ACC_W-1:0]     nabs_sr;
  logic [ACC_W-1:0]     lref_sr;
  logic [ACC_W-1:0]     ref_sr;
  logic [RAW_W-1:0]     raw_sr;
  logic [RAW_W-1:0]     prev_sr;
  logic [RAW_W-1:0]     lraw_sr;

  logic                 lvalid;
  logic                 ien;
  logic                 preset;
  logic                 first_step;
  side_t                index_side;
  logic [RAW_W-1:0]     last_cpr;

  chain_a_t             chain;
  chain_a_t             chain_next;
  logic                 c_snap;
  logic                 c_rel;

  logic [RAW_W-1:0]     fold;
  logic [RAW_W-1:0]     mag;
  logic                 mneg;
  logic                 capture;

  logic [OUT_W-1:0]     out_data;
  logic                 out_valid;

  logic [BITS_W-1:0]    bits_eff;
  logic [RAW_W-3:0]     win;
  logic                 short_rev;
  logic                 homing;
  logic                 in_raw;
  logic                 accept;
  logic                 div_start;
  logic                 load_out;
  logic                 abs_neg;

  digit_t               acc_dig;
  digit_t               abs_dig;
  digit_t               nabs_dig;
  digit_t               lref_dig;
  digit_t               home_dig;
  digit_t               mag_dig;
  digit_t               ref_dig;
  sum_t                 snap;
  sum_t                 rel;
  ref_src_t             ref_src;

  div_stat_t            div_stat;
  logic [RAW_W-1:0]     div_rem;

  logic [RAW_W-1:0]     half;
  logic [RAW_W-1:0]     fold_val;
  logic                 over_half;
  logic [RAW_W-1:0]     mag_val;
  side_t                side_new;
  logic                 capture_val;
  logic                 ien_out;

  always_comb begin
    if (bits_cfg == '0) begin
      bits_eff = BITS_W'(1);
    end else if (bits_cfg > BITS_W'(RAW_MAX_BITS)) begin
      bits_eff = BITS_W'(RAW_MAX_BITS);
    end else begin
      bits_eff = bits_cfg;
    end
  end

  assign win       = counts_per_rev[RAW_W-1:2];
  assign short_rev = (win == '0);
  assign homing    = ien && !short_rev;
  assign in_raw    = cnt < DIG_IDX_W'(RAW_DIGITS);
  assign accept    = s_tvalid && s_tready;
  assign abs_neg   = abs_sr[ACC_W-1];
  assign home_dig  = home_raw[DIGIT_W*cnt[RAW_IDX_W-1:0] +: DIGIT_W];

  emt_pass_a u_pass_a (
    .k          (cnt),
    .bits       (bits_eff),
    .first      (first_step),
    .raw_dig    (raw_sr[DIGIT_W-1:0]),
    .prev_dig   (prev_sr[DIGIT_W-1:0]),
    .lraw_dig   (lraw_sr[DIGIT_W-1:0]),
    .home_dig   (home_dig),
    .acc_dig    (acc_sr[DIGIT_W-1:0]),
    .chain      (chain),
    .chain_next (chain_next),
    .acc_out    (acc_dig),
    .abs_out    (abs_dig),
    .nabs_out   (nabs_dig),
    .lref_out   (lref_dig)
  );

  emt_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (abs_neg ? nabs_sr : abs_sr),
    .divisor   (counts_per_rev),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  // symmetric fold of the remainder into [-cpr/2, cpr/2]
  always_comb begin
    half = counts_per_rev >> 1;
    if (!abs_neg || div_rem == '0) begin
      fold_val = div_rem;
    end else begin
      fold_val = counts_per_rev - div_rem;
    end
    over_half = fold > half;
    mag_val   = over_half ? (counts_per_rev - fold) : fold;
    side_new  = over_half ? SIDE_NEG : SIDE_POS;
    capture_val = (index_side != SIDE_NONE) && (side_new != index_side) &&
                  (mag_val <= {2'b00, win});
  end

  // reference pass source: first sample or preset first, then latch, index capture, short-period reset
  always_comb begin
    if (first_step || preset) begin
      ref_src = REF_ABS;
    end else if (lvalid) begin
      ref_src = REF_LATCH;
    end else if (capture) begin
      ref_src = REF_SNAP;
    end else if (ien && short_rev) begin
      ref_src = REF_ABS;
    end else begin
      ref_src = REF_KEEP;
    end

    mag_dig = in_raw ? mag[DIGIT_W*cnt[RAW_IDX_W-1:0] +: DIGIT_W] : '0;
    snap    = add_digit(abs_sr[DIGIT_W-1:0], mneg ? mag_dig : ~mag_dig, c_snap);

    case (ref_src)
      REF_KEEP:  ref_dig = ref_sr[DIGIT_W-1:0];
      REF_SNAP:  ref_dig = snap.sum;
      REF_ABS:   ref_dig = abs_sr[DIGIT_W-1:0];
      REF_LATCH: ref_dig = lref_sr[DIGIT_W-1:0];
      default:   ref_dig = ref_sr[DIGIT_W-1:0];
    endcase

    rel = add_digit(abs_sr[DIGIT_W-1:0], ~ref_dig, c_rel);
  end

  assign ien_out = ien && !short_rev && !capture;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_PASS_A;
        end
      end
      ST_PASS_A: begin
        if (cnt == DIG_IDX_W'(N_DIGITS - 1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (homing) begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_PASS_C;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: state_next = ST_SIDE;
      ST_SIDE: state_next = ST_PASS_C;
      ST_PASS_C: begin
        if (cnt == DIG_IDX_W'(N_DIGITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      first_step     <= 1'b1;
      index_side     <= SIDE_NONE;
      last_cpr       <= '0;
      bits_cfg       <= BITS_W'(RAW_MAX_BITS);
      home_raw       <= '0;
      counts_per_rev <= '0;
      acc_sr         <= '0;
      prev_sr        <= '0;
      ref_sr         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_RAW_BITS:       bits_cfg       <= cfg_data[BITS_W-1:0];
          CFG_HOME_RAW:       home_raw       <= cfg_data[RAW_W-1:0];
          CFG_COUNTS_PER_REV: counts_per_rev <= cfg_data[RAW_W-1:0];
          CFG_START_COUNT:    acc_sr         <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        if (!s_tdata[2*RAW_W]) begin
          index_side <= SIDE_NONE;
        end else if (counts_per_rev != '0 && (first_step || counts_per_rev != last_cpr)) begin
          index_side <= SIDE_NONE;
        end
        last_cpr <= counts_per_rev;
      end

      if (state == ST_PASS_A) begin
        acc_sr <= {acc_dig, acc_sr[ACC_W-1:DIGIT_W]};
        if (in_raw) begin
          prev_sr <= {raw_sr[DIGIT_W-1:0], prev_sr[RAW_W-1:DIGIT_W]};
        end
      end

      if (state == ST_SIDE) begin
        index_side <= side_new;
      end

      if (state == ST_PASS_C) begin
        ref_sr <= {ref_dig, ref_sr[ACC_W-1:DIGIT_W]};
        if (cnt == DIG_IDX_W'(N_DIGITS - 1)) begin
          first_step <= 1'b0;
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_sr  <= s_tdata[RAW_W-1:0];
      lraw_sr <= s_tdata[2*RAW_W-1:RAW_W];
      ien     <= s_tdata[2*RAW_W];
      preset  <= s_tdata[2*RAW_W+1];
      lvalid  <= s_tuser;
      chain   <= CHAIN_A_INIT;
      cnt     <= '0;
    end

    case (state)
      ST_PASS_A: begin
        abs_sr  <= {abs_dig, abs_sr[ACC_W-1:DIGIT_W]};
        nabs_sr <= {nabs_dig, nabs_sr[ACC_W-1:DIGIT_W]};
        lref_sr <= {lref_dig, lref_sr[ACC_W-1:DIGIT_W]};
        if (in_raw) begin
          raw_sr  <= {{DIGIT_W{1'b0}}, raw_sr[RAW_W-1:DIGIT_W]};
          lraw_sr <= {{DIGIT_W{1'b0}}, lraw_sr[RAW_W-1:DIGIT_W]};
        end
        chain <= chain_next;
        cnt   <= cnt + DIG_IDX_W'(1);
      end
      ST_PREP: begin
        if (!homing) begin
          capture <= 1'b0;
          mneg    <= 1'b0;
          mag     <= '0;
          c_snap  <= 1'b1;
          c_rel   <= 1'b1;
        end
        cnt <= '0;
      end
      ST_FOLD: begin
        fold <= fold_val;
      end
      ST_SIDE: begin
        mag     <= mag_val;
        mneg    <= over_half;
        capture <= capture_val;
        // snap = abs + mag when the remainder is negative, abs - mag otherwise
        c_snap  <= !over_half;
        c_rel   <= 1'b1;
        cnt     <= '0;
      end
      ST_PASS_C: begin
        abs_sr  <= {abs_sr[DIGIT_W-1:0], abs_sr[ACC_W-1:DIGIT_W]};
        lref_sr <= {rel.sum, lref_sr[ACC_W-1:DIGIT_W]};
        c_snap  <= snap.carry;
        c_rel   <= rel.carry;
        cnt     <= cnt + DIG_IDX_W'(1);
      end
      default: ;
    endcase

    if (load_out) begin
      out_data <= {{(OUT_W - OUT_FIELDS_W){1'b0}}, ien_out, !abs_neg, abs_neg | chain.zero,
                   ref_sr, lref_sr, abs_sr, acc_sr};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIVIDE)
    else $error("divider running outside the divide phase");

  a_rel_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_data[3*ACC_W-1:2*ACC_W] ==
                  out_data[2*ACC_W-1:ACC_W] - out_data[4*ACC_W-1:3*ACC_W]))
    else $error("relative count does not match absolute minus reference");

  a_home_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_data[4*ACC_W+1] == !out_data[2*ACC_W-1]) &&
                  (out_data[4*ACC_W] || out_data[4*ACC_W+1])))
    else $error("home-side flags inconsistent with absolute count");

endmodule

// ===== hdl/emt_pass_a.sv =====
module emt_pass_a import emt_pkg::*; (
  input  logic [DIG_IDX_W-1:0] k,
  input  logic [BITS_W-1:0]    bits,
  input  logic                 first,
  input  digit_t               raw_dig,
  input  digit_t               prev_dig,
  input  digit_t               lraw_dig,
  input  digit_t               home_dig,
  input  digit_t               acc_dig,
  input  chain_a_t             chain,
  output chain_a_t             chain_next,
  output digit_t               acc_out,
  output digit_t               abs_out,
  output digit_t               nabs_out,
  output digit_t               lref_out
);

  logic   in_raw;
  digit_t raw_d;
  digit_t prev_d;
  digit_t lraw_d;
  digit_t home_d;
  wrap_t  d1;
  wrap_t  d2;
  wrap_t  d3;
  sum_t   s_acc;
  sum_t   s_abs;
  sum_t   s_lref;
  sum_t   s_neg;

  assign in_raw = k < DIG_IDX_W'(RAW_DIGITS);

  always_comb begin
    raw_d  = in_raw ? raw_dig : '0;
    // first sample: previous raw is taken from the accumulator's low bits
    prev_d = in_raw ? (first ? acc_dig : prev_dig) : '0;
    lraw_d = in_raw ? lraw_dig : '0;
    home_d = in_raw ? home_dig : '0;

    d1 = wrap_digit(raw_d, prev_d, chain.c_d1, chain.s_d1, k, bits);
    d2 = wrap_digit('0, home_d, chain.c_d2, chain.s_d2, k, bits);
    d3 = wrap_digit(lraw_d, raw_d, chain.c_d3, chain.s_d3, k, bits);

    s_acc  = add_digit(acc_dig, d1.ext, chain.c_acc);
    s_abs  = add_digit(s_acc.sum, d2.ext, chain.c_abs);
    s_lref = add_digit(s_abs.sum, d3.ext, chain.c_lref);
    s_neg  = add_digit('0, ~s_abs.sum, chain.c_neg);

    chain_next.c_d1   = d1.carry;
    chain_next.s_d1   = d1.sgn;
    chain_next.c_d2   = d2.carry;
    chain_next.s_d2   = d2.sgn;
    chain_next.c_d3   = d3.carry;
    chain_next.s_d3   = d3.sgn;
    chain_next.c_acc  = s_acc.carry;
    chain_next.c_abs  = s_abs.carry;
    chain_next.c_lref = s_lref.carry;
    chain_next.c_neg  = s_neg.carry;
    chain_next.zero   = chain.zero & (s_abs.sum == '0);

    acc_out  = s_acc.sum;
    abs_out  = s_abs.sum;
    nabs_out = s_neg.sum;
    lref_out = s_lref.sum;
  end

endmodule

// ===== hdl/emt_divider.sv =====
module emt_divider import emt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [RAW_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [RAW_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ACC_W-1:0]     dvd;
  logic [RAW_W-1:0]     rem;
  logic [RAW_W-1:0]     rem_next;
  logic [RAW_W:0]       trial;

  // restoring step, one quotient bit a cycle, MSB first
  always_comb begin
    trial = {rem, dvd[ACC_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = RAW_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(ACC_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[ACC_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.last = busy && (cnt == DIV_CNT_W'(ACC_W - 1));
  assign remainder = rem;

endmodule

// ===== tb/encoder_multiturn_tracker_tb.sv =====
module encoder_multiturn_tracker_tb import emt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // highest field first, matching the result tdata layout
  typedef struct packed {
    logic        ien_out;
    logic        above;
    logic        below;
    logic [63:0] ref_c;
    logic [63:0] rel;
    logic [63:0] abs_c;
    logic [63:0] enc;
  } count_set_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // tracker image, values as they stand after reset
  logic [5:0]  trk_bits = 6'd32;
  logic [31:0] trk_home = '0;
  logic [31:0] trk_cpr = '0;
  logic [63:0] trk_acc = '0;
  logic [31:0] prev_sample = '0;
  logic [63:0] trk_ref = '0;
  side_t       trk_side = SIDE_NONE;
  bit          trk_first = 1'b1;
  logic [31:0] trk_last_cpr = '0;

  count_set_t pending_counts[$];
  int fail_count = 0;
  bit steady = 1'b0;

  encoder_multiturn_tracker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [5:0] cur_bits();
    if (trk_bits == 6'd0) return 6'd1;
    if (trk_bits > 6'd32) return 6'd32;
    return trk_bits;
  endfunction

  function automatic logic [31:0] low_mask(logic [5:0] bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    return m[31:0];
  endfunction

  // (a - b) mod 2^bits, sign-extended to 64 bits
  function automatic logic [63:0] wrap_step(logic [31:0] a, logic [31:0] b, logic [5:0] bits);
    logic [63:0] d;
    logic [63:0] sgn;
    d = {32'd0, (a - b) & low_mask(bits)};
    sgn = 64'd1 << (bits - 6'd1);
    return (d ^ sgn) - sgn;
  endfunction

  task automatic advance_tracker(logic [31:0] raw, logic [31:0] lraw, bit lvalid, bit ien_in,
                                 bit preset);
    logic [5:0]  bits;
    logic [63:0] absc;
    logic [63:0] cpr64;
    logic [63:0] win;
    logic [63:0] r;
    logic [63:0] nm;
    logic [63:0] mag;
    side_t       side;
    bit          ien;
    count_set_t  res;
    bits = cur_bits();
    if (trk_cpr != 0 && (trk_first || trk_cpr != trk_last_cpr)) trk_side = SIDE_NONE;
    trk_last_cpr = trk_cpr;
    if (trk_first) prev_sample = trk_acc[31:0] & low_mask(bits);
    trk_acc = trk_acc + wrap_step(raw, prev_sample, bits);
    prev_sample = raw;
    absc = trk_acc + wrap_step(32'd0, trk_home, bits);
    ien = ien_in;
    if (ien) begin
      cpr64 = {32'd0, trk_cpr};
      win = cpr64 >> 2;
      if (win == 0) begin
        ien = 1'b0;
        trk_ref = absc;
      end else begin
        // symmetric remainder in [-cpr/2, cpr/2]
        if (!absc[63]) begin
          r = absc % cpr64;
        end else begin
          nm = (64'd0 - absc) % cpr64;
          r = (nm == 0) ? 64'd0 : cpr64 - nm;
        end
        if (r > (cpr64 >> 1)) r = r - cpr64;
        side = r[63] ? SIDE_NEG : SIDE_POS;
        mag = r[63] ? 64'd0 - r : r;
        if (trk_side != SIDE_NONE && side != trk_side && mag <= win) begin
          ien = 1'b0;
          trk_ref = absc - r;
        end
        trk_side = side;
      end
    end else begin
      trk_side = SIDE_NONE;
    end
    if (lvalid) trk_ref = absc + wrap_step(lraw, raw, bits);
    if (trk_first || preset) trk_ref = absc;
    res.enc = trk_acc;
    res.abs_c = absc;
    res.rel = absc - trk_ref;
    res.ref_c = trk_ref;
    res.below = absc[63] || absc == 0;
    res.above = !absc[63];
    res.ien_out = ien;
    trk_first = 1'b0;
    pending_counts.push_back(res);
  endtask

  // called on a clock edge; leaves tvalid high after the transaction
  task automatic send_sample(logic [31:0] raw, logic [31:0] lraw, bit lvalid, bit ien,
                             bit preset);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= IN_W'({preset, ien, lraw, raw});
    s_tuser <= lvalid;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    advance_tracker(raw, lraw, lvalid, ien, preset);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [63:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RAW_BITS:       trk_bits = val[5:0];
      CFG_HOME_RAW:       trk_home = val[31:0];
      CFG_COUNTS_PER_REV: trk_cpr = val[31:0];
      CFG_START_COUNT:    trk_acc = val;
      default: ;
    endcase
  endtask

  // next raw sample a bounded random step away, junk above the significant bits
  function automatic logic [31:0] next_walk(logic [31:0] span);
    logic [31:0] mask;
    logic [31:0] mag;
    logic [31:0] raw;
    mask = low_mask(cur_bits());
    mag = $urandom_range(0, span);
    raw = $urandom_range(0, 1) ? prev_sample + mag : prev_sample - mag;
    return (raw & mask) | ($urandom & ~mask);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // result side
  initial begin
    int stall;
    count_set_t exp_c;
    count_set_t got;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got = m_tdata[$bits(count_set_t)-1:0];
      if (pending_counts.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        fail_count++;
      end else begin
        exp_c = pending_counts.pop_front();
        check_field("encoder_count", exp_c.enc, got.enc);
        check_field("absolute_count", exp_c.abs_c, got.abs_c);
        check_field("relative_count", exp_c.rel, got.rel);
        check_field("reference_count", exp_c.ref_c, got.ref_c);
        check_field("at_or_below_home", exp_c.below, got.below);
        check_field("at_or_above_home", exp_c.above, got.above);
        check_field("index_enable_out", exp_c.ien_out, got.ien_out);
      end
    end
  end

  task automatic test_directed();
    // seed from a negative start count on the very first sample
    set_reg(CFG_START_COUNT, 64'hFFFF_FFFF_FFFF_FFF0);
    send_sample(32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    // index request with no period: plain reset of the reference
    send_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
    send_sample(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1);
    // home at all ones, count sitting right on home
    set_reg(CFG_HOME_RAW, 64'h0000_0000_FFFF_FFFF);
    set_reg(CFG_START_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(prev_sample, 32'h0, 1'b0, 1'b0, 1'b0);
    send_sample(prev_sample + 32'd1, 32'h0, 1'b0, 1'b0, 1'b0);
    send_sample(prev_sample - 32'd2, 32'h0, 1'b0, 1'b0, 1'b0);
    // smallest period with a window: cross upwards, then downwards through zero
    set_reg(CFG_HOME_RAW, 64'd0);
    set_reg(CFG_COUNTS_PER_REV, 64'd4);
    set_reg(CFG_START_COUNT, 64'd0);
    for (int i = 0; i < 3; i++) send_sample(prev_sample + 32'd1, 32'h0, 1'b0, 1'b1, 1'b0);
    send_sample(prev_sample + 32'd2, 32'h0, 1'b0, 1'b1, 1'b0);
    send_sample(prev_sample - 32'd1, 32'h0, 1'b0, 1'b1, 1'b0);
    send_sample(prev_sample - 32'd1, 32'h0, 1'b0, 1'b1, 1'b0);
    send_sample(prev_sample, 32'h0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) send_sample(prev_sample - 32'd1, 32'h0, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_small_period();
    for (int c = 0; c < 4; c++) begin
      set_reg(CFG_COUNTS_PER_REV, {$urandom, 32'(c)});
      for (int i = 0; i < 10; i++)
        send_sample(next_walk(32'd50), $urandom, $urandom_range(0, 3) == 0,
                    1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_index_homing();
    logic [31:0] cpr;
    logic [31:0] raw;
    logic [31:0] lraw;
    for (int s = 0; s < 8; s++) begin
      cpr = (s == 0) ? 32'd5 : (s == 1) ? 32'd7 : $urandom_range(4, 300);
      set_reg(CFG_RAW_BITS, {$urandom, 26'd0, 6'($urandom_range(9, 32))});
      set_reg(CFG_HOME_RAW, {$urandom, $urandom});
      set_reg(CFG_COUNTS_PER_REV, {32'd0, cpr});
      set_reg(CFG_START_COUNT, 64'($signed($urandom_range(0, 2_000_000)) - 1_000_000));
      for (int i = 0; i < 60; i++) begin
        raw = next_walk(cpr / 3 + 1);
        lraw = $urandom_range(0, 1) ? raw + $urandom_range(0, 20) - 10 : $urandom;
        send_sample(raw, lraw, $urandom_range(0, 11) == 0, $urandom_range(0, 19) != 0,
                    $urandom_range(0, 24) == 0);
        // let every result come home before carrying on
        if (i == 30) wait_drained();
      end
    end
  endtask

  task automatic test_wrap();
    logic [5:0] bits;
    for (int s = 0; s < 8; s++) begin
      bits = (s == 0) ? 6'd1 : (s == 1) ? 6'd32 : (s == 2) ? 6'd2 : (s == 3) ? 6'd31
             : 6'($urandom_range(1, 32));
      steady = (s == 2 || s == 5);
      set_reg(CFG_RAW_BITS, {58'd0, bits});
      set_reg(CFG_HOME_RAW, (s == 0) ? 64'd0 : (s == 1) ? 64'hFFFF_FFFF : {$urandom, $urandom});
      set_reg(CFG_COUNTS_PER_REV, $urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom});
      set_reg(CFG_START_COUNT, {$urandom, $urandom});
      for (int i = 0; i < 55; i++)
        send_sample($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
  endtask

  task automatic test_extremes();
    logic [31:0] cpr;
    logic [63:0] start;
    set_reg(CFG_RAW_BITS, 64'd32);
    set_reg(CFG_HOME_RAW, 64'd0);
    for (int s = 0; s < 4; s++) begin
      cpr = (s == 0) ? 32'hFFFF_FFFF : (s == 1) ? 32'h8000_0000 : $urandom | 32'h1000_0000;
      start = (s == 0) ? 64'h7FFF_FFFF_FFFF_FF00 : (s == 1) ? 64'h8000_0000_0000_0080
              : (s == 2) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
      set_reg(CFG_COUNTS_PER_REV, {32'd0, cpr});
      set_reg(CFG_START_COUNT, start);
      for (int i = 0; i < 60; i++)
        send_sample(next_walk(cpr / 3), $urandom, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RAW_BITS;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_period();
    test_index_homing();
    test_wrap();
    test_extremes();
    wait_drained();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/emt_pkg.sv
hdl/emt_pass_a.sv
hdl/emt_divider.sv
hdl/encoder_multiturn_tracker.sv
tb/encoder_multiturn_tracker_tb.sv
